// ----- sv/dupdet_pkg.sv -----
// Shared types and constants of the duplicate frame detector.
package dupdet_pkg;

  // Table size and field widths
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ADDR_W        = 48;
  localparam int unsigned SEQ_W         = 12;
  localparam int unsigned FRAG_W        = 4;

  // One stored table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [FRAG_W-1:0] frag;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming request, start a scan
    logic scan;    // step the table scan
    logic update;  // apply table update, load result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_cmp;  // last entry is being compared this cycle
  } sts_t;

endpackage

// ----- sv/dupdet_in_if.sv -----
// Request channel carrying one received frame's header fields.
interface dupdet_in_if;
  logic                           valid;
  logic                           ready;
  logic [dupdet_pkg::ADDR_W-1:0]  transmitter_address;
  logic [dupdet_pkg::SEQ_W-1:0]   sequence_number;
  logic [dupdet_pkg::FRAG_W-1:0]  fragment_number;
  logic                           retry_bit;

  modport source (
    output valid, transmitter_address, sequence_number, fragment_number, retry_bit,
    input  ready
  );
  modport sink (
    input  valid, transmitter_address, sequence_number, fragment_number, retry_bit,
    output ready
  );
endinterface

// ----- sv/dupdet_out_if.sv -----
// Result channel carrying the verdict for one frame.
interface dupdet_out_if;
  logic valid;
  logic ready;
  logic is_duplicate;
  logic address_was_new;
  logic entry_evicted;

  modport source (
    output valid, is_duplicate, address_was_new, entry_evicted,
    input  ready
  );
  modport sink (
    input  valid, is_duplicate, address_was_new, entry_evicted,
    output ready
  );
endinterface

// ----- sv/dupdet_dp.sv -----
// Datapath: request capture, table memory, scan compare and table update.
module dupdet_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dupdet_pkg::cmd_t              cmd_i,
  output dupdet_pkg::sts_t              sts_o,
  input  logic [dupdet_pkg::ADDR_W-1:0] addr_i,
  input  logic [dupdet_pkg::SEQ_W-1:0]  seq_i,
  input  logic [dupdet_pkg::FRAG_W-1:0] frag_i,
  input  logic                          retry_i,
  output logic                          dup_o,
  output logic                          new_o,
  output logic                          evict_o
);

  localparam logic [dupdet_pkg::IDX_W-1:0] LastIdx =
    dupdet_pkg::IDX_W'(dupdet_pkg::TABLE_ENTRIES - 1);

  // Captured request
  logic [dupdet_pkg::ADDR_W-1:0] addr_q;
  logic [dupdet_pkg::SEQ_W-1:0]  seq_q;
  logic [dupdet_pkg::FRAG_W-1:0] frag_q;
  logic                          retry_q;

  // Table storage
  dupdet_pkg::entry_t                  mem_q [dupdet_pkg::TABLE_ENTRIES];
  dupdet_pkg::entry_t                  rd_q;
  logic [dupdet_pkg::TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [dupdet_pkg::IDX_W-1:0]        ptr_q, ptr_d;

  // Scan state
  logic [dupdet_pkg::IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [dupdet_pkg::IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic                         issue_vld_q, issue_vld_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic                         found_q, found_d;
  logic                         free_vld_q, free_vld_d;
  logic [dupdet_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [dupdet_pkg::IDX_W-1:0] free_idx_q, free_idx_d;
  logic [dupdet_pkg::SEQ_W-1:0] hit_seq_q, hit_seq_d;
  logic [dupdet_pkg::FRAG_W-1:0] hit_frag_q, hit_frag_d;

  // Results
  logic dup_q, dup_d, new_q, new_d, evict_q, evict_d;

  // Write port
  logic                         wr_en;
  logic [dupdet_pkg::IDX_W-1:0] wr_idx;
  dupdet_pkg::entry_t           wr_data;

  logic is_dup;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= addr_i;
      seq_q   <= seq_i;
      frag_q  <= frag_i;
      retry_q <= retry_i;
    end
  end

  // Table read and write, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && issue_vld_q) begin
      rd_q <= mem_q[scan_idx_q];
    end
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
  end

  // Scan: issue a read each cycle, compare the entry read in the previous cycle
  always_comb begin
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    issue_vld_d = issue_vld_q;
    cmp_vld_d   = cmp_vld_q;
    found_d     = found_q;
    free_vld_d  = free_vld_q;
    hit_idx_d   = hit_idx_q;
    free_idx_d  = free_idx_q;
    hit_seq_d   = hit_seq_q;
    hit_frag_d  = hit_frag_q;
    if (cmd_i.load) begin
      scan_idx_d  = '0;
      issue_vld_d = 1'b1;
      cmp_vld_d   = 1'b0;
      found_d     = 1'b0;
      free_vld_d  = 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_d = issue_vld_q;
      cmp_idx_d = scan_idx_q;
      if (issue_vld_q) begin
        if (scan_idx_q == LastIdx) begin
          issue_vld_d = 1'b0;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      if (cmp_vld_q) begin
        if (valid_q[cmp_idx_q]) begin
          if (!found_q && rd_q.addr == addr_q) begin
            found_d    = 1'b1;
            hit_idx_d  = cmp_idx_q;
            hit_seq_d  = rd_q.seq;
            hit_frag_d = rd_q.frag;
          end
        end else if (!free_vld_q) begin
          free_vld_d = 1'b1;
          free_idx_d = cmp_idx_q;
        end
      end
    end
  end

  assign sts_o.last_cmp = cmp_vld_q && (cmp_idx_q == LastIdx);

  // Update: refresh a non-duplicate hit, or insert into a free entry or the round-robin victim
  assign is_dup = found_q && (hit_seq_q == seq_q) && (hit_frag_q == frag_q) && retry_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = hit_idx_q;
    wr_data = '{addr: addr_q, seq: seq_q, frag: frag_q};
    valid_d = valid_q;
    ptr_d   = ptr_q;
    dup_d   = dup_q;
    new_d   = new_q;
    evict_d = evict_q;
    if (cmd_i.update) begin
      dup_d   = is_dup;
      new_d   = !found_q;
      evict_d = !found_q && !free_vld_q;
      if (found_q) begin
        wr_en = !is_dup;
      end else begin
        wr_en = 1'b1;
        if (free_vld_q) begin
          wr_idx = free_idx_q;
        end else begin
          wr_idx = ptr_q;
          ptr_d  = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
        end
        valid_d[wr_idx] = 1'b1;
      end
    end
  end

  // Control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ptr_q       <= '0;
      issue_vld_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      free_vld_q  <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      ptr_q       <= ptr_d;
      issue_vld_q <= issue_vld_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      free_vld_q  <= free_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    hit_seq_q  <= hit_seq_d;
    hit_frag_q <= hit_frag_d;
    dup_q      <= dup_d;
    new_q      <= new_d;
    evict_q    <= evict_d;
  end

  assign dup_o   = dup_q;
  assign new_o   = new_q;
  assign evict_o = evict_q;

endmodule

// ----- sv/dupdet_ctrl.sv -----
// Controller: sequences capture, table scan, update and the result handshake.
module dupdet_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dupdet_pkg::cmd_t cmd_o,
  input  dupdet_pkg::sts_t sts_i
);

  dupdet_pkg::state_e state_q, state_d;
  logic               out_vld_q, out_vld_d;
  logic               go;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dupdet_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result register is free when empty or being taken this cycle
  assign go = !out_vld_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      dupdet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dupdet_pkg::ST_SCAN;
        end
      end
      dupdet_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last_cmp) begin
          state_d = dupdet_pkg::ST_UPDATE;
        end
      end
      dupdet_pkg::ST_UPDATE: begin
        if (go) begin
          cmd_o.update = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = dupdet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dupdet_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

// ----- sv/wifi_duplicate_frame_detector_unit.sv -----
// Top level of the receive-side duplicate frame detector.
//
// Usage: frame_i takes one request per received non-QoS frame (transmitter
// address, sequence number, fragment number, retry bit). result_o returns one
// verdict per request in order: is_duplicate, address_was_new, entry_evicted.
// Both channels complete a transfer when valid and ready are high at a clock.
// The table memory has one read port, so the scan reads one entry per cycle;
// the read data is registered before the compare, and the update follows the
// scan in its own state. Only one request is in work at a time.
// The result sits in an output register, so the next request is accepted and
// scanned while the previous result waits; if the receiver stalls, the
// update of that next request waits until the result register is taken.
// Reset (rst_ni low, asynchronous) clears all entry valid bits, the
// round-robin replace pointer and both channels' valid state; no clearing
// pass is needed and the block accepts a request in the first cycle after.
module wifi_duplicate_frame_detector_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  dupdet_in_if.sink    frame_i,
  dupdet_out_if.source result_o
);

  dupdet_pkg::cmd_t cmd;
  dupdet_pkg::sts_t sts;

  dupdet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (frame_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dupdet_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .addr_i  (frame_i.transmitter_address),
    .seq_i   (frame_i.sequence_number),
    .frag_i  (frame_i.fragment_number),
    .retry_i (frame_i.retry_bit),
    .dup_o   (result_o.is_duplicate),
    .new_o   (result_o.address_was_new),
    .evict_o (result_o.entry_evicted)
  );

endmodule

// ----- dv/wifi_duplicate_frame_detector_unit_tb.sv -----
// Testbench of the duplicate frame detector: directed table plus random traffic, scoreboarded.
`timescale 1ns / 1ps

module wifi_duplicate_frame_detector_unit_tb;

  localparam int unsigned TABLE_ENTRIES = dupdet_pkg::TABLE_ENTRIES;
  localparam int unsigned ADDR_W        = dupdet_pkg::ADDR_W;
  localparam int unsigned SEQ_W         = dupdet_pkg::SEQ_W;
  localparam int unsigned FRAG_W        = dupdet_pkg::FRAG_W;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_FRAMES = 1225;
  localparam int POOL_MAX      = 40;
  localparam int MAX_WAIT      = 11;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int HOLD_AT       = 300;   // verdict count that starts the hold-off
  localparam int DRAIN_CYCLES  = 3 * (TABLE_ENTRIES + 3);
  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up

  // One verdict as returned on the result channel
  typedef struct packed {
    logic dup;
    logic was_new;
    logic evicted;
  } verdict_t;

  // One frame request, with an optional typed-in verdict
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [FRAG_W-1:0] frag;
    logic              retry;
    logic              has_exp;
    verdict_t          want;
  } frame_req_t;

  localparam verdict_t V_NONE  = '{dup: 1'b0, was_new: 1'b0, evicted: 1'b0};
  localparam verdict_t V_KNOWN = '{dup: 1'b0, was_new: 1'b0, evicted: 1'b0};
  localparam verdict_t V_DUP   = '{dup: 1'b1, was_new: 1'b0, evicted: 1'b0};
  localparam verdict_t V_NEW   = '{dup: 1'b0, was_new: 1'b1, evicted: 1'b0};
  localparam verdict_t V_EVICT = '{dup: 1'b0, was_new: 1'b1, evicted: 1'b1};

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  logic clk;
  logic rst_n;

  dupdet_in_if  frame_if ();
  dupdet_out_if result_if ();

  wifi_duplicate_frame_detector_unit i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .frame_i  (frame_if),
    .result_o (result_if)
  );

  // Shadow copy of the address table
  logic              shadow_valid [TABLE_ENTRIES];
  logic [ADDR_W-1:0] shadow_addr  [TABLE_ENTRIES];
  logic [SEQ_W-1:0]  shadow_seq   [TABLE_ENTRIES];
  logic [FRAG_W-1:0] shadow_frag  [TABLE_ENTRIES];
  int                shadow_victim;

  frame_req_t directed_tbl [DIRECTED_ROWS];
  frame_req_t frame_q[$];
  verdict_t   verdict_q[$];
  int         error_count;
  int         verdicts_taken;
  bit         frames_done;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Predict the verdict for one accepted frame and update the shadow table
  function automatic verdict_t predict_verdict(frame_req_t f);
    verdict_t v;
    int       hit;
    int       slot;
    bit       found;
    bit       have_free;
    v         = V_NONE;
    hit       = 0;
    slot      = 0;
    found     = 1'b0;
    have_free = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_valid[i]) begin
        if (!found && shadow_addr[i] == f.addr) begin
          found = 1'b1;
          hit   = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        slot      = i;
      end
    end
    if (found) begin
      if (shadow_seq[hit] == f.seq && shadow_frag[hit] == f.frag && f.retry) begin
        v.dup = 1'b1;
      end else begin
        shadow_seq[hit]  = f.seq;
        shadow_frag[hit] = f.frag;
      end
    end else begin
      v.was_new = 1'b1;
      // Table full: round-robin victim
      if (!have_free) begin
        slot          = shadow_victim;
        shadow_victim = (shadow_victim == TABLE_ENTRIES - 1) ? 0 : shadow_victim + 1;
        v.evicted     = 1'b1;
      end
      shadow_valid[slot] = 1'b1;
      shadow_addr[slot]  = f.addr;
      shadow_seq[slot]   = f.seq;
      shadow_frag[slot]  = f.frag;
    end
    return v;
  endfunction

  // Request side: offer frames with random gaps and bursts
  task automatic send_frames();
    frame_req_t req;
    verdict_t   v;
    int         gap;
    bit         burst;
    burst = 1'b0;
    while (frame_q.size() > 0) begin
      req = frame_q.pop_front();
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
        frame_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_if.valid               <= 1'b1;
      frame_if.transmitter_address <= req.addr;
      frame_if.sequence_number     <= req.seq;
      frame_if.fragment_number     <= req.frag;
      frame_if.retry_bit           <= req.retry;
      do @(posedge clk); while (!frame_if.ready);
      // Accepted at this edge
      v = predict_verdict(req);
      verdict_q.push_back(req.has_exp ? req.want : v);
    end
    frame_if.valid <= 1'b0;
    frames_done = 1'b1;
  endtask

  // Result side: random stalls, one long hold-off, compare against the oldest expectation
  task automatic take_verdicts();
    verdict_t want;
    int       stall;
    bit       burst;
    bit       held;
    burst = 1'b0;
    held  = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (!held && verdicts_taken >= HOLD_AT) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      verdicts_taken++;
      if (verdict_q.size() == 0) begin
        report_error("verdict with no frame pending");
      end else begin
        want = verdict_q.pop_front();
        if (result_if.is_duplicate !== want.dup)
          report_error($sformatf("verdict %0d is_duplicate got %b want %b",
                                 verdicts_taken, result_if.is_duplicate, want.dup));
        if (result_if.address_was_new !== want.was_new)
          report_error($sformatf("verdict %0d address_was_new got %b want %b",
                                 verdicts_taken, result_if.address_was_new, want.was_new));
        if (result_if.entry_evicted !== want.evicted)
          report_error($sformatf("verdict %0d entry_evicted got %b want %b",
                                 verdicts_taken, result_if.entry_evicted, want.evicted));
      end
    end
  endtask

  // Watchdog: give up after too long without any transfer
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (frame_if.valid && frame_if.ready) ||
          (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL wifi_duplicate_frame_detector_unit");
    $finish;
  end

  // Main sequence
  initial begin : main
    frame_req_t        req;
    logic [ADDR_W-1:0] pool_addr [POOL_MAX];
    logic [SEQ_W-1:0]  pool_seq  [POOL_MAX];
    logic [FRAG_W-1:0] pool_frag [POOL_MAX];
    int                pool_size;
    int                k;
    int                pick;
    int                kind;

    rst_n                        = 1'b0;
    frame_if.valid               = 1'b0;
    frame_if.transmitter_address = '0;
    frame_if.sequence_number     = '0;
    frame_if.fragment_number     = '0;
    frame_if.retry_bit           = 1'b0;
    result_if.ready              = 1'b0;
    error_count                  = 0;
    verdicts_taken               = 0;
    frames_done                  = 1'b0;
    shadow_victim                = 0;
    pool_size                    = 3;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_addr[i]  = '0;
      shadow_seq[i]   = '0;
      shadow_frag[i]  = '0;
    end

    // Directed table: retry on a new address, duplicates, extremes, fill, round-robin eviction
    directed_tbl[0] = '{'0,       12'h000, 4'h0, 1'b1, 1'b1, V_NEW};
    directed_tbl[1] = '{'0,       12'h000, 4'h0, 1'b1, 1'b1, V_DUP};
    directed_tbl[2] = '{'0,       12'h000, 4'h0, 1'b0, 1'b1, V_KNOWN};
    directed_tbl[3] = '{ADDR_MAX, 12'hFFF, 4'hF, 1'b0, 1'b1, V_NEW};
    directed_tbl[4] = '{ADDR_MAX, 12'hFFF, 4'hF, 1'b1, 1'b1, V_DUP};
    directed_tbl[5] = '{ADDR_MAX, 12'hFFE, 4'hF, 1'b1, 1'b1, V_KNOWN};
    directed_tbl[6] = '{ADDR_MAX, 12'hFFE, 4'hF, 1'b1, 1'b1, V_DUP};
    directed_tbl[7] = '{ADDR_MAX, 12'hFFE, 4'hE, 1'b1, 1'b1, V_KNOWN};
    // Fill the rest of the table; checked by the predictor
    for (int i = 8; i < 22; i++)
      directed_tbl[i] = '{ADDR_W'(i - 7), SEQ_W'(i), FRAG_W'(i), 1'b0, 1'b0, V_NONE};
    // Table full: victims in round-robin order, starting at entry zero
    directed_tbl[22] = '{ADDR_W'(15), 12'h123, 4'h5, 1'b1, 1'b1, V_EVICT};
    directed_tbl[23] = '{'0,          12'h000, 4'h0, 1'b1, 1'b1, V_EVICT};
    directed_tbl[24] = '{ADDR_MAX,    12'hFFE, 4'hE, 1'b1, 1'b1, V_EVICT};
    for (int i = 0; i < DIRECTED_ROWS; i++)
      frame_q.push_back(directed_tbl[i]);

    // Random traffic: mostly per-transmitter sequences, some noise
    for (int i = 0; i < POOL_MAX; i++) begin
      pool_addr[i] = ADDR_W'({$urandom, $urandom});
      pool_seq[i]  = SEQ_W'($urandom);
      pool_frag[i] = '0;
    end
    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n % 125 == 0) begin
        case ($urandom_range(0, 3))
          0:       pool_size = 3;
          1:       pool_size = TABLE_ENTRIES;
          2:       pool_size = TABLE_ENTRIES + 1;
          default: pool_size = POOL_MAX;
        endcase
      end
      k    = $urandom_range(0, pool_size - 1);
      pick = $urandom_range(0, 99);
      req  = '0;
      if (pick < 6) begin
        // stray transmitter
        req.addr  = ADDR_W'({$urandom, $urandom});
        req.seq   = SEQ_W'($urandom);
        req.frag  = FRAG_W'($urandom);
        req.retry = 1'($urandom_range(0, 1));
      end else begin
        req.addr = pool_addr[k];
        if (pick < 10) begin
          // broken sequence: arbitrary numbers from a known transmitter
          req.seq   = SEQ_W'($urandom);
          req.frag  = FRAG_W'($urandom);
          req.retry = 1'($urandom_range(0, 1));
        end else begin
          kind = $urandom_range(0, 99);
          if (kind < 35) begin
            // retransmission
            req.seq   = pool_seq[k];
            req.frag  = pool_frag[k];
            req.retry = 1'b1;
          end else if (kind < 45) begin
            // same numbers without retry
            req.seq   = pool_seq[k];
            req.frag  = pool_frag[k];
            req.retry = 1'b0;
          end else if (kind < 70) begin
            // next fragment
            req.seq   = pool_seq[k];
            req.frag  = pool_frag[k] + 1'b1;
            req.retry = ($urandom_range(0, 3) == 0);
          end else begin
            // next MSDU
            req.seq   = pool_seq[k] + 1'b1;
            req.frag  = '0;
            req.retry = ($urandom_range(0, 3) == 0);
          end
        end
        pool_seq[k]  = req.seq;
        pool_frag[k] = req.frag;
      end
      // occasionally a transmitter leaves and a new one shows up
      if ($urandom_range(0, 49) == 0)
        pool_addr[$urandom_range(0, POOL_MAX - 1)] = ADDR_W'({$urandom, $urandom});
      frame_q.push_back(req);
    end

    // Reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      send_frames();
      take_verdicts();
    join_none

    wait (frames_done);
    wait (verdict_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("PASS wifi_duplicate_frame_detector_unit");
    else
      $display("FAIL wifi_duplicate_frame_detector_unit");
    $finish;
  end

endmodule
